[hdl/eight_channel_led_pwm_serializer_assert.svh]
// Assertion macros for the LED PWM serializer.
// Both expect clk in scope; ELPS_ASSERT also expects arst_n.
`ifndef EIGHT_CHANNEL_LED_PWM_SERIALIZER_ASSERT_SVH
`define EIGHT_CHANNEL_LED_PWM_SERIALIZER_ASSERT_SVH

// Checked only outside reset.
`define ELPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ELPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/elps_pkg.sv]
`default_nettype none
package elps_pkg;

	localparam int PWM_STEPS = 20;
	localparam int LED_COUNT = 8;

	localparam int OP_W       = 2;
	localparam int IDX_W      = 3;
	localparam int LEVEL_IN_W = 8;
	localparam int BIT_POS_W  = 3;

	localparam int LVL_W     = $clog2(PWM_STEPS + 1);
	localparam int STEP_W    = $clog2(PWM_STEPS);
	localparam int LED_IDX_W = $clog2(LED_COUNT);

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_SOLO  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		logic                 valid;
		logic [LED_COUNT-1:0] pattern;
	} ser_load_t;

	function automatic logic [LVL_W-1:0] reset_level(input int i);
		int v;
		begin
			v = 2 * i;
			if (v > PWM_STEPS) begin
				return LVL_W'(PWM_STEPS);
			end
			return LVL_W'(v);
		end
	endfunction

endpackage
`default_nettype wire

[hdl/elps_req_if.sv]
`default_nettype none
interface elps_req_if;
	import elps_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic [IDX_W-1:0]      led_index;
	logic [LEVEL_IN_W-1:0] level;

	modport source (output valid, output operation, output led_index, output level,
		input ready);
	modport sink (input valid, input operation, input led_index, input level,
		output ready);
endinterface
`default_nettype wire

[hdl/elps_res_if.sv]
`default_nettype none
interface elps_res_if;
	import elps_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 serial_bit;
	logic [BIT_POS_W-1:0] bit_position;
	logic                 latch_now;

	modport source (output valid, output serial_bit, output bit_position, output latch_now,
		input ready);
	modport sink (input valid, input serial_bit, input bit_position, input latch_now,
		output ready);
endinterface
`default_nettype wire

[hdl/elps_serializer.sv]
`default_nettype none
`include "eight_channel_led_pwm_serializer_assert.svh"
module elps_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  elps_pkg::ser_load_t load,
	output logic                load_ready,
	elps_res_if.source          result
);
	import elps_pkg::*;

	logic                 busy_q;
	logic [LED_IDX_W-1:0] pos_q;
	logic [LED_COUNT-1:0] pattern_q;
	logic                 last;
	logic                 take;

	assign last       = (pos_q == LED_IDX_W'(LED_COUNT - 1));
	assign take       = busy_q && result.ready;
	assign load_ready = !busy_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load.valid) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (take) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load.valid) begin
			pattern_q <= load.pattern;
		end
	end

	assign result.valid        = busy_q;
	assign result.serial_bit   = pattern_q[pos_q];
	assign result.bit_position = BIT_POS_W'(pos_q);
	assign result.latch_now    = last;

	`ELPS_ASSERT(a_load_when_free, load.valid |-> load_ready, "pattern loaded while busy")
	`ELPS_ASSERT(a_run_ends, (take && last && !load.valid) |=> !busy_q, "run did not end")
	`ELPS_ASSERT(a_load_starts, load.valid |=> (busy_q && pos_q == '0), "run did not start")

endmodule
`default_nettype wire

[hdl/eight_channel_led_pwm_serializer.sv]
// Path: a tick request is taken into the input register, then loaded into the output
// shifter once that is free, and the shifter then offers its first serial bit.
// Throughput: level requests (set, solo, all off) go at one per cycle unless a tick
// waits in the input register; a tick holds the shifter until its eight bits are taken.
// Reset (arst_n low, asynchronous): levels go to 2*i, the step counter to zero,
// the input register and the shifter empty.
`default_nettype none
`include "eight_channel_led_pwm_serializer_assert.svh"
module eight_channel_led_pwm_serializer (
	input  logic       clk,
	input  logic       arst_n,
	elps_req_if.sink   request,
	elps_res_if.source result
);
	import elps_pkg::*;

	logic                  valid_s1;
	op_t                   op_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [LEVEL_IN_W-1:0] level_s1;

	logic [LVL_W-1:0]      levels_q [LED_COUNT];
	logic [STEP_W-1:0]     step_q;

	logic                  advance;
	logic                  is_tick;
	logic                  idx_ok;
	logic [LVL_W-1:0]      clamped;
	logic [LED_COUNT-1:0]  pattern;
	ser_load_t             load;
	logic                  load_ready;

	assign is_tick       = (op_s1 == OP_TICK);
	assign advance       = valid_s1 && (!is_tick || load_ready);
	assign request.ready = !valid_s1 || advance;
	assign idx_ok        = (int'(idx_s1) < LED_COUNT);
	assign clamped       = (level_s1 > LEVEL_IN_W'(PWM_STEPS)) ? LVL_W'(PWM_STEPS)
		: level_s1[LVL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			op_s1    <= op_t'(request.operation);
			idx_s1   <= request.led_index;
			level_s1 <= request.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				levels_q[i] <= reset_level(i);
			end
		end else if (advance) begin
			unique case (op_s1)
				OP_TICK: begin
				end
				OP_SET: begin
					if (idx_ok) begin
						levels_q[idx_s1[LED_IDX_W-1:0]] <= clamped;
					end
				end
				OP_SOLO: begin
					for (int i = 0; i < LED_COUNT; i++) begin
						levels_q[i] <= '0;
					end
					if (idx_ok) begin
						levels_q[idx_s1[LED_IDX_W-1:0]] <= LVL_W'(PWM_STEPS);
					end
				end
				OP_CLEAR: begin
					for (int i = 0; i < LED_COUNT; i++) begin
						levels_q[i] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (advance && is_tick) begin
			step_q <= (step_q >= STEP_W'(PWM_STEPS - 1)) ? '0 : step_q + 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < LED_COUNT; i++) begin
			pattern[i] = (LVL_W'(step_q) < levels_q[i]);
		end
	end

	assign load.valid   = advance && is_tick;
	assign load.pattern = pattern;

	elps_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_ready (load_ready),
		.result     (result)
	);

	`ELPS_ASSERT_ALWAYS(a_step_range, step_q < STEP_W'(PWM_STEPS), "step out of range")
	`ELPS_ASSERT(a_level_no_stall, (valid_s1 && !is_tick) |-> advance, "level request stalled")
	`ELPS_ASSERT(a_tick_step, (advance && is_tick && step_q == '0) |=> step_q != '0,
		"step did not advance")

endmodule
`default_nettype wire
